// ----- rtl/nth_multiset_permutation_core_defines.svh -----
// Assertion macros shared by the multiset permutation unranking RTL.
`ifndef NTH_MULTISET_PERMUTATION_CORE_DEFINES_SVH
`define NTH_MULTISET_PERMUTATION_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every clock edge outside reset.
`define NMP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmp assertion failed");
// Next-cycle implication, checked at every clock edge outside reset.
`define NMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmp assertion failed");
`else
`define NMP_ASSERT_IMPL(lbl, ante, cons)
`define NMP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/nmp_pkg.sv -----
// Package with constants and types of the multiset permutation unranking core.
package nmp_pkg;
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int MAX_LENGTH_DEF    = 20;
    localparam int SYM_W             = 5;
    localparam int CNT_W             = 5;
    localparam int RANK_W            = 62;
    // Product width of a rank-sized value times a count.
    localparam int PROD_W            = RANK_W + CNT_W;

    // Request to the shared multiply-divide unit: q = a * m / d.
    typedef struct packed {
        logic              start;
        logic [RANK_W-1:0] a;
        logic [CNT_W-1:0]  m;
        logic [CNT_W-1:0]  d;
    } md_req_t;

    // Answer of the shared multiply-divide unit.
    typedef struct packed {
        logic              done;
        logic [RANK_W-1:0] q;
    } md_rsp_t;
endpackage

// ----- rtl/nmp_muldiv.sv -----
// Shared unit computing a * m / d with a restoring divider, one quotient bit per cycle.
module nmp_muldiv (
    input  logic            clk,
    input  logic            rst_n,
    input  nmp_pkg::md_req_t req,
    output nmp_pkg::md_rsp_t rsp
);
    import nmp_pkg::*;

    localparam int CW = $clog2(PROD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [CNT_W:0]    trial;

    // On start, load the operands; else one restoring step: shift in the next dividend bit and try the subtraction.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        trial     = {rem_reg, p_reg[PROD_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(PROD_W);
            p_next    = PROD_W'(req.a) * PROD_W'(req.m);
            rem_next  = '0;
            d_next    = req.d;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, d_reg});
                p_next   = {p_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                p_next   = {p_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = p_reg[RANK_W-1:0];
endmodule

// ----- rtl/nth_multiset_permutation_core.sv -----
// Top level of the multiset permutation unranking core: loader, sequencer, output register.
//
// Input channel s_*: one beat per multiset symbol. s_tlast marks the last symbol,
// whose beat also carries the 1-based rank. Symbols load at one beat per cycle.
// After the last beat the block drops s_tready and computes the permutation count
// len!/prod(c!) by len multiply-divide steps, then walks the symbols in ascending
// order, sizing each block of permutations as M*c/r on the shared
// multiply-divide unit, waiting for each answer before the next step.
// Output channel m_*: one beat per symbol of the permutation, m_tlast on the
// final one. A rank of zero, a rank above the count or an empty multiset gives
// one beat with m_tuser (error) and m_tlast set and symbol zero.
// A result waits in the output register while m_tready is low; the sequencer
// holds until it is taken. After the final beat all counts clear and s_tready
// rises again. Reset clears counts and returns the block to loading.
`include "nth_multiset_permutation_core_defines.svh"
module nth_multiset_permutation_core #(
    parameter int ALPHABET_SIZE = nmp_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_LENGTH    = nmp_pkg::MAX_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [4:0] symbol, [66:5] rank, zero fill above
    input  logic        s_tlast,   // last_symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [4:0] out_symbol, zero fill above
    output logic        m_tlast,   // last_out
    output logic        m_tuser    // [0] rank_error
);
    import nmp_pkg::*;

    localparam int AW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int IW   = $clog2(ALPHABET_SIZE + 1);
    localparam int ASW  = (IW > SYM_W) ? IW + 1 : SYM_W + 1;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_TOT   = 3'd1;
    localparam logic [2:0] ST_TOTW  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SCANW = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg [ALPHABET_SIZE];
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [RANK_W-1:0] mult_reg, mult_next;
    logic [SYM_W-1:0]  osym_reg, osym_next;
    logic              olast_reg, olast_next;
    logic              oerr_reg, oerr_next;

    logic [SYM_W-1:0]  in_sym;
    logic [RANK_W-1:0] in_rank;
    logic              s_acc, m_acc, idx_end;
    logic [AW-1:0]     rd_addr;
    logic [CNT_W-1:0]  cnt_rd;
    logic              cnt_we, cnt_clr;
    logic [CNT_W-1:0]  cnt_wval;
    md_req_t           md_req;
    md_rsp_t           md_rsp;

    assign in_sym  = s_tdata[SYM_W-1:0];
    assign in_rank = s_tdata[SYM_W+RANK_W-1:SYM_W];
    assign s_acc   = s_tvalid && s_tready;
    assign m_acc   = m_tvalid && m_tready;
    assign idx_end = (ASW'(idx_reg) >= ASW'(ALPHABET_SIZE));

    // Single read port of the count registers: the loader or the scan index.
    assign rd_addr = (state_reg == ST_LOAD) ? AW'(in_sym) : idx_reg[AW-1:0];
    assign cnt_rd  = cnt_reg[rd_addr];

    nmp_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Sequencer: load, count permutations, check rank, pick symbols, emit.
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        idx_next   = idx_reg;
        rank_next  = rank_reg;
        mult_next  = mult_reg;
        osym_next  = osym_reg;
        olast_next = olast_reg;
        oerr_next  = oerr_reg;
        cnt_we     = 1'b0;
        cnt_clr    = 1'b0;
        cnt_wval   = cnt_rd;
        md_req     = '{start: 1'b0, a: mult_reg, m: cnt_rd, d: r_reg};
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    if ((ASW'(in_sym) < ASW'(ALPHABET_SIZE)) &&
                        (len_reg < CNT_W'(MAX_LENGTH)))
                    begin
                        cnt_we   = 1'b1;
                        cnt_wval = cnt_rd + 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        rank_next  = in_rank;
                        mult_next  = RANK_W'(1);
                        n_next     = '0;
                        k_next     = '0;
                        idx_next   = '0;
                        state_next = ST_TOT;
                    end
                end
            end
            ST_TOT:
            begin
                if (idx_end)
                    state_next = ST_CHECK;
                else if (k_reg < cnt_rd)
                begin
                    md_req.start = 1'b1;
                    md_req.m     = n_reg + 1'b1;
                    md_req.d     = k_reg + 1'b1;
                    n_next       = n_reg + 1'b1;
                    k_next       = k_reg + 1'b1;
                    state_next   = ST_TOTW;
                end
                else
                begin
                    k_next   = '0;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TOTW:
            begin
                if (md_rsp.done)
                begin
                    mult_next  = md_rsp.q;
                    state_next = ST_TOT;
                end
            end
            ST_CHECK:
            begin
                idx_next = '0;
                if ((len_reg == '0) || (rank_reg == '0) || (rank_reg > mult_reg))
                begin
                    osym_next  = '0;
                    olast_next = 1'b1;
                    oerr_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    rank_next  = rank_reg - 1'b1;
                    r_next     = len_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_end)
                begin
                    // Unreachable after the rank check; end the run cleanly.
                    cnt_clr    = 1'b1;
                    len_next   = '0;
                    state_next = ST_LOAD;
                end
                else if (cnt_rd == '0)
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    md_req.start = 1'b1;
                    state_next   = ST_SCANW;
                end
            end
            ST_SCANW:
            begin
                if (md_rsp.done)
                begin
                    if (rank_reg < md_rsp.q)
                    begin
                        mult_next  = md_rsp.q;
                        cnt_we     = 1'b1;
                        cnt_wval   = cnt_rd - 1'b1;
                        r_next     = r_reg - 1'b1;
                        osym_next  = SYM_W'(idx_reg);
                        olast_next = (r_reg == CNT_W'(1));
                        oerr_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rank_next  = rank_reg - md_rsp.q;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_acc)
                begin
                    idx_next = '0;
                    if (olast_reg)
                    begin
                        cnt_clr    = 1'b1;
                        len_next   = '0;
                        rank_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers and symbol counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            len_reg   <= '0;
            for (int i = 0; i < ALPHABET_SIZE; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (cnt_clr)
            begin
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    cnt_reg[i] <= '0;
            end
            else if (cnt_we)
                cnt_reg[rd_addr] <= cnt_wval;
        end
    end

    // Working values and output payload.
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        k_reg     <= k_next;
        r_reg     <= r_next;
        idx_reg   <= idx_next;
        rank_reg  <= rank_next;
        mult_reg  <= mult_next;
        osym_reg  <= osym_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'b000, osym_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oerr_reg;

    // Checks on the sequencer.
    `NMP_ASSERT_IMPL(a_not_both, s_tready, !m_tvalid)
    `NMP_ASSERT_IMPL(a_err_last, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0))
    `NMP_ASSERT_NEXT(a_back_load, m_tvalid && m_tready && m_tlast, s_tready)
    `NMP_ASSERT_NEXT(a_start_busy, s_tvalid && s_tready && s_tlast, !s_tready)
endmodule
